@@ rtl/core/assert_macros.svh @@
// Assertion helpers; every use relies on clk and rst being in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

@@ rtl/core/sfsr_pkg.sv @@
package sfsr_pkg;

  localparam int MAX_FRAMES      = 512;
  localparam int NUM_BINS        = 512;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int PHASE_W  = FRAME_W + PHASE_FRAC_BITS;
  localparam int INC_W    = PHASE_W + 2;
  localparam int STORE_AW = FRAME_W + BIN_W;
  localparam int WORD_W   = 32;
  localparam int SETV_W   = 27;
  localparam int CMD_W    = 3;

  // Modulo unit: signed Q16 operand, one quotient bit per step
  localparam int WRAP_IN_W  = INC_W + 1;
  localparam int WRAP_STEPS = FRAME_W + 3;
  localparam int HI_W       = WRAP_IN_W - PHASE_FRAC_BITS;
  localparam int T_W        = CNT_W + WRAP_STEPS - 1;
  localparam int STEP_W     = $clog2(WRAP_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CNT_W-1:0] FC_RESET = CNT_W'(344);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE   = 3'd0,
    CMD_RECORD    = 3'd1,
    CMD_PLAY      = 3'd2,
    CMD_SET_INC   = 3'd3,
    CMD_SET_PHASE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN_RD,
    ST_FRM1,
    ST_FRM2,
    ST_LERP,
    ST_WRAP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] amp;
    logic [WORD_W-1:0] freq;
  } frame_entry_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [INC_W-1:0]   inc;
  } bin_entry_t;

  // Frame count saturated to 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] fc_raw);
    logic [CNT_W-1:0] fc;
    fc = fc_raw;
    if (fc_raw == '0) fc = CNT_W'(1);
    if (fc_raw > CNT_W'(MAX_FRAMES)) fc = CNT_W'(MAX_FRAMES);
    return fc;
  endfunction

endpackage

@@ rtl/core/sfsr_ram.sv @@
module sfsr_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sfsr_wrap.sv @@
`include "assert_macros.svh"

module sfsr_wrap import sfsr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [WRAP_IN_W-1:0] value,
  input  logic [CNT_W-1:0]            fc,
  output logic                        busy,
  output logic [PHASE_W-1:0]          result
);

  logic [T_W-1:0]             t_q;
  logic [T_W-1:0]             d_q;
  logic [CNT_W-1:0]           fc_q;
  logic [PHASE_FRAC_BITS-1:0] low_q;
  logic [STEP_W-1:0]          steps;

  logic [HI_W-1:0] hi;
  logic [T_W-1:0]  hi_ext;
  logic [T_W-1:0]  offset;
  logic [T_W-1:0]  t_init;

  // Integer part of the operand; a negative one is lifted by a multiple of fc
  always_comb begin
    hi     = value[WRAP_IN_W-1:PHASE_FRAC_BITS];
    hi_ext = {{(T_W-HI_W){hi[HI_W-1]}}, hi};
    offset = T_W'(fc) << (WRAP_STEPS - 1);
    t_init = hi_ext + (hi[HI_W-1] ? offset : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(WRAP_STEPS);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_q   <= t_init;
      d_q   <= offset;
      fc_q  <= fc;
      low_q <= value[PHASE_FRAC_BITS-1:0];
    end else if (busy) begin
      if (t_q >= d_q) begin
        t_q <= t_q - d_q;
      end
      d_q <= d_q >> 1;
    end
  end

  assign result = {t_q[FRAME_W-1:0], low_q};

  `ASSERT_IMPLY(a_wrap_rem_below_count, $fell(busy), t_q < T_W'(fc_q),
                "modulo unit finished with remainder not below frame count")

endmodule

@@ rtl/core/sfsr_lerp.sv @@
module sfsr_lerp import sfsr_pkg::*; (
  input  logic                       clk,
  input  logic [WORD_W-1:0]          a1,
  input  logic [WORD_W-1:0]          a2,
  input  logic [PHASE_FRAC_BITS-1:0] frac,
  output logic [WORD_W-1:0]          res
);

  localparam int DIFF_W = WORD_W + 1;
  localparam int PROD_W = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int SCL_W  = PROD_W - PHASE_FRAC_BITS;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_q;
  logic [WORD_W-1:0]        base_q;
  logic signed [PROD_W-1:0] rounded;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SCL_W-1:0]  sum;

  assign diff = $signed({a2[WORD_W-1], a2}) - $signed({a1[WORD_W-1], a1});

  always_ff @(posedge clk) begin
    prod_q <= diff * $signed({1'b0, frac});
    base_q <= a1;
  end

  // Round to nearest, ties up, then drop the fraction bits
  always_comb begin
    rounded = prod_q + PROD_W'(1 << (PHASE_FRAC_BITS - 1));
    scaled  = rounded[PROD_W-1:PHASE_FRAC_BITS];
    sum     = $signed({{(SCL_W-WORD_W){base_q[WORD_W-1]}}, base_q}) + scaled;
    res     = sum[WORD_W-1:0];
  end

endmodule

@@ rtl/core/spectral_frame_store_resampler_top.sv @@
// Spectral frame store with per-bin resampling playback.
// Input channel: in_valid/in_stall carry one request (cmd, bin, amp_in, freq_in,
// last_bin, set_value). Output channel: out_valid/out_stall carry exactly one
// result per request: valid_res, amp_out, freq_out (zero unless a bin was
// played) and the capture status recording/frames_captured after the request.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 frame_count,
// 1 interpolate); other indexes are dropped. Write only while the block is idle.
// After reset a clearing pass zeroes the frame store and the per-bin phase and
// increment tables, one entry per cycle, with in_stall high.
// Acquire, record and ignored requests go straight to the result; set increment
// first reads the bin table, and set phase and play (in either read mode) also
// run the phase wrap modulo unit (12 steps, one per cycle).
// One request is in flight at a time; the next is accepted in the cycle after
// its result enters the output register. A stalled result holds in the output
// register while the next request is taken and worked on.
`include "assert_macros.svh"

module spectral_frame_store_resampler_top import sfsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [BIN_W-1:0]         bin,
  input  logic signed [WORD_W-1:0] amp_in,
  input  logic signed [WORD_W-1:0] freq_in,
  input  logic                     last_bin,
  input  logic signed [SETV_W-1:0] set_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     valid_res,
  output logic signed [WORD_W-1:0] amp_out,
  output logic signed [WORD_W-1:0] freq_out,
  output logic                     recording,
  output logic [CNT_W-1:0]         frames_captured
);

  localparam int ENTRY_W = $bits(frame_entry_t);
  localparam int BENT_W  = $bits(bin_entry_t);
  localparam logic [BIN_W:0] BIN_LIMIT = (BIN_W + 1)'(NUM_BINS);

  state_t state, state_next;

  logic [STORE_AW-1:0] clr_addr;
  logic [CNT_W-1:0]    frame_count_q;
  logic                interp_q;
  logic                capturing;
  logic [CNT_W-1:0]    cap_cnt;

  cmd_t                cmd_q;
  logic [BIN_W-1:0]    bin_q;
  logic [SETV_W-1:0]   sv_q;
  logic [PHASE_W-1:0]  ph_q;
  logic [INC_W-1:0]    inc_q;
  logic [FRAME_W-1:0]  ip_q;
  logic [PHASE_FRAC_BITS-1:0] frac_q;
  frame_entry_t        e1_q;
  logic                res_valid_q;
  logic [WORD_W-1:0]   res_amp_q;
  logic [WORD_W-1:0]   res_freq_q;

  // Store and table ports
  logic                store_we, store_re;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [ENTRY_W-1:0]  store_wdata, store_rdata;
  frame_entry_t        store_rd;
  logic                bin_we, bin_re;
  logic [BIN_W-1:0]    bin_waddr;
  logic [BENT_W-1:0]   bin_wdata, bin_rdata;
  bin_entry_t          bin_rd;

  logic                        wrap_start, wrap_busy;
  logic signed [WRAP_IN_W-1:0] wrap_value;
  logic [PHASE_W-1:0]          wrap_res;

  logic [WORD_W-1:0] lerp_amp, lerp_freq;

  cmd_t             cmd_in;
  logic             in_acc, bin_ok, needs_bin, rec_write, push;
  logic [CNT_W-1:0] fc, fcm1, ip_inc;
  logic [FRAME_W-1:0] ip_raw, ip_c, ip2;
  logic signed [WRAP_IN_W-1:0] fcq_s, sv_x, sat_inc;

  assign cmd_in   = cmd_t'(cmd);
  assign fc       = eff_count(frame_count_q);
  assign fcm1     = fc - 1'b1;
  assign in_acc   = in_valid && !in_stall;
  assign bin_ok   = {1'b0, bin} < BIN_LIMIT;
  assign store_rd = frame_entry_t'(store_rdata);
  assign bin_rd   = bin_entry_t'(bin_rdata);
  assign push     = (state == ST_RESULT) && (!out_valid || !out_stall);

  assign needs_bin = bin_ok && ((cmd_in == CMD_PLAY && !capturing) ||
                                cmd_in == CMD_SET_INC || cmd_in == CMD_SET_PHASE);
  assign rec_write = in_acc && cmd_in == CMD_RECORD && capturing && bin_ok && (cap_cnt < fc);

  // Read frame clamped to count-1; next frame wraps to zero
  always_comb begin
    ip_raw = bin_rd.phase[PHASE_W-1:PHASE_FRAC_BITS];
    ip_c   = ({1'b0, ip_raw} > fcm1) ? fcm1[FRAME_W-1:0] : ip_raw;
    ip_inc = {1'b0, ip_q} + 1'b1;
    ip2    = (ip_inc == fc) ? '0 : ip_inc[FRAME_W-1:0];
  end

  // Increment saturates to plus or minus count in Q16
  always_comb begin
    fcq_s   = $signed({2'b00, fc, {PHASE_FRAC_BITS{1'b0}}});
    sv_x    = $signed({sv_q[SETV_W-1], sv_q});
    sat_inc = sv_x;
    if (sv_x > fcq_s) sat_inc = fcq_s;
    if (sv_x < -fcq_s) sat_inc = -fcq_s;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_next = needs_bin ? ST_BIN_RD : ST_RESULT;
      end
      ST_BIN_RD: begin
        case (cmd_q)
          CMD_PLAY:      state_next = ST_FRM1;
          CMD_SET_PHASE: state_next = ST_WRAP;
          default:       state_next = ST_RESULT;
        endcase
      end
      ST_FRM1:   state_next = interp_q ? ST_FRM2 : ST_WRAP;
      ST_FRM2:   state_next = ST_LERP;
      ST_LERP:   state_next = ST_WRAP;
      ST_WRAP: begin
        if (!wrap_busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (push) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    store_we    = rec_write;
    store_waddr = {cap_cnt[FRAME_W-1:0], bin};
    store_wdata = {amp_in, freq_in};
    store_re    = 1'b0;
    store_raddr = {ip_c, bin_q};
    bin_re      = in_acc;
    bin_we      = 1'b0;
    bin_waddr   = bin_q;
    bin_wdata   = {wrap_res, inc_q};
    wrap_start  = 1'b0;
    wrap_value  = $signed({sv_q[SETV_W-1], sv_q});
    case (state)
      ST_CLEAR: begin
        store_we    = 1'b1;
        store_waddr = clr_addr;
        store_wdata = '0;
        bin_we      = 1'b1;
        bin_waddr   = clr_addr[BIN_W-1:0];
        bin_wdata   = '0;
      end
      ST_BIN_RD: begin
        store_re = (cmd_q == CMD_PLAY);
        if (cmd_q == CMD_SET_INC) begin
          bin_we    = 1'b1;
          bin_wdata = {bin_rd.phase, sat_inc[INC_W-1:0]};
        end
        wrap_start = (cmd_q == CMD_SET_PHASE);
      end
      ST_FRM1: begin
        store_re    = interp_q;
        store_raddr = {ip2, bin_q};
        wrap_start  = 1'b1;
        wrap_value  = $signed({3'b000, ph_q}) + $signed({inc_q[INC_W-1], inc_q});
      end
      ST_WRAP: begin
        bin_we = !wrap_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count_q <= FC_RESET;
      interp_q      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT: frame_count_q <= cfg_data;
        CFG_INTERPOLATE: interp_q      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing <= 1'b0;
      cap_cnt   <= '0;
    end else if (in_acc) begin
      case (cmd_in)
        CMD_ACQUIRE: begin
          capturing <= 1'b1;
          cap_cnt   <= '0;
        end
        CMD_RECORD: begin
          if (capturing && bin_ok) begin
            if (cap_cnt >= fc) begin
              capturing <= 1'b0;
            end else if (last_bin) begin
              cap_cnt <= cap_cnt + 1'b1;
              if (cap_cnt + 1'b1 >= fc) capturing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q       <= cmd_in;
      bin_q       <= bin;
      sv_q        <= set_value;
      res_valid_q <= 1'b0;
      res_amp_q   <= '0;
      res_freq_q  <= '0;
    end
    if (state == ST_BIN_RD) begin
      ph_q   <= bin_rd.phase;
      inc_q  <= bin_rd.inc;
      ip_q   <= ip_c;
      frac_q <= bin_rd.phase[PHASE_FRAC_BITS-1:0];
    end
    if (state == ST_FRM1) begin
      e1_q        <= store_rd;
      res_valid_q <= 1'b1;
      res_amp_q   <= store_rd.amp;
      res_freq_q  <= store_rd.freq;
    end
    if (state == ST_LERP) begin
      res_amp_q  <= lerp_amp;
      res_freq_q <= lerp_freq;
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      valid_res       <= res_valid_q;
      amp_out         <= res_amp_q;
      freq_out        <= res_freq_q;
      recording       <= capturing;
      frames_captured <= cap_cnt;
    end
  end

  sfsr_ram #(
    .ADDR_W (STORE_AW),
    .DATA_W (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  sfsr_ram #(
    .ADDR_W (BIN_W),
    .DATA_W (BENT_W)
  ) u_bin_tab (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin),
    .rdata (bin_rdata)
  );

  sfsr_wrap u_wrap (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .value  (wrap_value),
    .fc     (fc),
    .busy   (wrap_busy),
    .result (wrap_res)
  );

  sfsr_lerp u_lerp_amp (
    .clk  (clk),
    .a1   (e1_q.amp),
    .a2   (store_rd.amp),
    .frac (frac_q),
    .res  (lerp_amp)
  );

  sfsr_lerp u_lerp_freq (
    .clk  (clk),
    .a1   (e1_q.freq),
    .a2   (store_rd.freq),
    .frac (frac_q),
    .res  (lerp_freq)
  );

  `ASSERT_CLK(a_cap_cnt_range, cap_cnt <= CNT_W'(MAX_FRAMES),
              "capture count beyond frame store depth")
  `ASSERT_IMPLY(a_play_not_recording, out_valid && valid_res, !recording,
                "played bin reported while recording")
  `ASSERT_IMPLY(a_out_from_result, $rose(out_valid), $past(state == ST_RESULT),
                "output loaded outside the result state")

endmodule

@@ test/tb_spectral_frame_store_resampler_top.sv @@
`timescale 1ns / 1ps

import sfsr_pkg::*;

typedef struct {
  bit                 played;
  bit [WORD_W-1:0]    amp;
  bit [WORD_W-1:0]    freq;
  bit                 rec;
  bit [CNT_W-1:0]     frames;
} bin_result_t;

class frame_store_scoreboard;
  bit [WORD_W-1:0] amp_mem [MAX_FRAMES*NUM_BINS];
  bit [WORD_W-1:0] freq_mem [MAX_FRAMES*NUM_BINS];
  longint          phase_tab [NUM_BINS];
  longint          inc_tab [NUM_BINS];
  bit              capturing;
  int unsigned     frames_done;
  bit [CNT_W-1:0]  frame_reg;
  bit              interp_on;
  bin_result_t     due_q [$];
  int              errors;

  function new();
    frame_reg = FC_RESET;
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function longint frames_eff();
    if (frame_reg == '0) return 1;
    if (frame_reg > MAX_FRAMES) return MAX_FRAMES;
    return longint'(frame_reg);
  endfunction

  function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_COUNT) frame_reg = val;
    else if (idx == CFG_INTERPOLATE) interp_on = val[0];
  endfunction

  static function longint wrap_frames(longint v, longint m);
    longint r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // a + (frac * (b - a)) / 2^FRAC, rounded half up
  static function bit [WORD_W-1:0] blend(bit [WORD_W-1:0] a, bit [WORD_W-1:0] b,
                                         longint frac);
    longint x, y, p;
    x = longint'($signed(a));
    y = longint'($signed(b));
    p = (y - x) * frac + (longint'(1) << (PHASE_FRAC_BITS - 1));
    return WORD_W'(x + (p >>> PHASE_FRAC_BITS));
  endfunction

  function void note_request(bit [CMD_W-1:0] op, bit [BIN_W-1:0] b, bit [WORD_W-1:0] a,
                             bit [WORD_W-1:0] f, bit last, bit [SETV_W-1:0] sv_raw);
    longint      fc, fcq, sv, ph, ip, frac;
    int          row, row2;
    bit          bin_ok;
    bin_result_t r;
    fc = frames_eff();
    fcq = fc << PHASE_FRAC_BITS;
    sv = longint'($signed(sv_raw));
    bin_ok = (b < NUM_BINS);
    r = '{default: 0};
    case (op)
      CMD_ACQUIRE: begin
        capturing = 1'b1;
        frames_done = 0;
      end
      CMD_RECORD: if (capturing && bin_ok) begin
        if (frames_done >= fc) begin
          capturing = 1'b0;
        end else begin
          row = int'(frames_done) * NUM_BINS + b;
          amp_mem[row] = a;
          freq_mem[row] = f;
          if (last) begin
            frames_done++;
            if (frames_done >= fc) capturing = 1'b0;
          end
        end
      end
      CMD_PLAY: if (!capturing && bin_ok) begin
        ph = phase_tab[b];
        ip = ph >> PHASE_FRAC_BITS;
        frac = ph & ((longint'(1) << PHASE_FRAC_BITS) - 1);
        // clamp a phase left over from a larger frame count
        if (ip > fc - 1) ip = fc - 1;
        row = int'(ip) * NUM_BINS + b;
        if (interp_on) begin
          row2 = int'((ip + 1) % fc) * NUM_BINS + b;
          r.amp = blend(amp_mem[row], amp_mem[row2], frac);
          r.freq = blend(freq_mem[row], freq_mem[row2], frac);
        end else begin
          r.amp = amp_mem[row];
          r.freq = freq_mem[row];
        end
        r.played = 1'b1;
        phase_tab[b] = wrap_frames(ph + inc_tab[b], fcq);
      end
      CMD_SET_INC: if (bin_ok) begin
        if (sv > fcq) sv = fcq;
        if (sv < -fcq) sv = -fcq;
        inc_tab[b] = sv;
      end
      CMD_SET_PHASE: if (bin_ok) begin
        phase_tab[b] = wrap_frames(sv, fcq);
      end
      default: ;
    endcase
    r.rec = capturing;
    r.frames = CNT_W'(frames_done);
    due_q.push_back(r);
  endfunction

  function void cmp_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic played, logic [WORD_W-1:0] a, logic [WORD_W-1:0] f,
                             logic rec, logic [CNT_W-1:0] frames);
    bin_result_t e;
    if (due_q.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = due_q.pop_front();
    cmp_field("valid_res", WORD_W'(e.played), WORD_W'(played));
    cmp_field("amp_out", e.amp, a);
    cmp_field("freq_out", e.freq, f);
    cmp_field("recording", WORD_W'(e.rec), WORD_W'(rec));
    cmp_field("frames_captured", WORD_W'(e.frames), WORD_W'(frames));
  endfunction
endclass

module tb_spectral_frame_store_resampler_top;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_WAIT    = 18;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = '0;
  logic [BIN_W-1:0]         bin = '0;
  logic signed [WORD_W-1:0] amp_in = '0;
  logic signed [WORD_W-1:0] freq_in = '0;
  logic                     last_bin = 1'b0;
  logic signed [SETV_W-1:0] set_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     valid_res;
  logic signed [WORD_W-1:0] amp_out;
  logic signed [WORD_W-1:0] freq_out;
  logic                     recording;
  logic [CNT_W-1:0]         frames_captured;

  frame_store_scoreboard sb;
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;
  int n_items = 0;
  int stall_left = 0;
  int cycle_count = 0;

  spectral_frame_store_resampler_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check each accepted result, then stall for a random while unless take_calm is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(valid_res, amp_out, freq_out, recording, frames_captured);
        stall_left = take_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(bit [CMD_W-1:0] op, bit [BIN_W-1:0] b, bit [WORD_W-1:0] a,
                          bit [WORD_W-1:0] f, bit last, bit [SETV_W-1:0] sv);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= op;
    bin <= b;
    amp_in <= a;
    freq_in <= f;
    last_bin <= last;
    set_value <= sv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, b, a, f, last, sv);
    if (op <= CMD_SET_PHASE) n_items++;
  endtask

  task automatic send_noise();
    send_req(CMD_W'($urandom_range(int'(CMD_RECORD), (1 << CMD_W) - 1)), BIN_W'($urandom),
             $urandom, $urandom, 1'($urandom_range(0, 1)), SETV_W'($urandom));
  endtask

  // hold off until every request has its result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic bit [SETV_W-1:0] pick_setv(int fc_eff);
    longint span;
    span = (longint'(fc_eff) << PHASE_FRAC_BITS) * 3 / 2;
    case ($urandom_range(0, 7))
      0: return SETV_W'($urandom);
      1: return {1'b1, {(SETV_W-1){1'b0}}};
      2: return {1'b0, {(SETV_W-1){1'b1}}};
      3: return SETV_W'(longint'($urandom_range(0, 4)) << PHASE_FRAC_BITS);
      default: return SETV_W'(longint'($urandom_range(0, int'(2 * span))) - span);
    endcase
  endfunction

  initial begin
    bit [BIN_W-1:0] hot [$];
    bit [CNT_W-1:0] fc_raw;
    int             fc_eff, n_rec, target, sess;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);
    // wait out the clearing pass
    while (in_stall) @(posedge clk);

    // directed: reset settings, cleared store
    send_req(CMD_PLAY, '0, $urandom, $urandom, 1'b1, SETV_W'($urandom));
    wait_idle();
    write_cfg(CFG_FRAME_COUNT, CFG_DATA_W'(2));
    write_cfg(CFG_INTERPOLATE, '0);
    send_req(CMD_ACQUIRE, BIN_W'($urandom), $urandom, $urandom, 1'b1, SETV_W'($urandom));
    send_req(CMD_PLAY, '0, $urandom, $urandom, 1'b0, SETV_W'($urandom));
    send_req(CMD_RECORD, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
    send_req(CMD_RECORD, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '0);
    send_req(CMD_RECORD, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '1);
    send_req(CMD_RECORD, '1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '1);
    // record after capture finished: drop
    send_req(CMD_RECORD, '0, '1, '1, 1'b1, '0);
    for (int u = int'(CMD_SET_PHASE) + 1; u < (1 << CMD_W); u++)
      send_req(CMD_W'(u), '1, '1, '1, 1'b1, '1);
    send_req(CMD_SET_INC, '0, $urandom, $urandom, 1'b0, {1'b0, {(SETV_W-1){1'b1}}});
    send_req(CMD_SET_INC, '1, $urandom, $urandom, 1'b0, {1'b1, {(SETV_W-1){1'b0}}});
    send_req(CMD_SET_PHASE, '0, $urandom, $urandom, 1'b0, '1);
    send_req(CMD_SET_PHASE, '1, $urandom, $urandom, 1'b0,
             SETV_W'(1 << (PHASE_FRAC_BITS - 1)));
    send_req(CMD_PLAY, '0, $urandom, $urandom, 1'b0, SETV_W'($urandom));
    send_req(CMD_PLAY, '1, $urandom, $urandom, 1'b0, SETV_W'($urandom));
    wait_idle();
    write_cfg(CFG_INTERPOLATE, CFG_DATA_W'(1));
    send_req(CMD_PLAY, '0, $urandom, $urandom, 1'b0, SETV_W'($urandom));
    send_req(CMD_PLAY, '1, $urandom, $urandom, 1'b0, SETV_W'($urandom));
    // phase set under a large count, then played under a small one
    wait_idle();
    write_cfg(CFG_FRAME_COUNT, CFG_DATA_W'(MAX_FRAMES));
    send_req(CMD_SET_PHASE, BIN_W'(7), $urandom, $urandom, 1'b0,
             SETV_W'((300 << PHASE_FRAC_BITS) + 'h4321));
    wait_idle();
    write_cfg(CFG_FRAME_COUNT, CFG_DATA_W'(2));
    send_req(CMD_PLAY, BIN_W'(7), $urandom, $urandom, 1'b0, SETV_W'($urandom));
    send_req(CMD_PLAY, BIN_W'(7), $urandom, $urandom, 1'b0, SETV_W'($urandom));
    // count lowered below the frames already held during a capture
    wait_idle();
    write_cfg(CFG_FRAME_COUNT, CFG_DATA_W'(8));
    send_req(CMD_ACQUIRE, BIN_W'($urandom), $urandom, $urandom, 1'b0, SETV_W'($urandom));
    repeat (3)
      send_req(CMD_RECORD, BIN_W'(3), $urandom, $urandom, 1'b1, SETV_W'($urandom));
    wait_idle();
    write_cfg(CFG_FRAME_COUNT, CFG_DATA_W'(2));
    send_req(CMD_RECORD, BIN_W'(3), $urandom, $urandom, 1'b1, SETV_W'($urandom));

    // random sessions: configure, capture, set up bins, play them back
    target = n_items + 500;
    sess = 0;
    while (n_items < target) begin
      case (sess < 4 ? sess : $urandom_range(4, 12))
        0: fc_raw = '0;
        1: fc_raw = CNT_W'(MAX_FRAMES);
        2: fc_raw = '1;
        3: fc_raw = CNT_W'(1);
        4: fc_raw = CNT_W'($urandom_range(MAX_FRAMES + 1, (1 << CNT_W) - 1));
        5: fc_raw = CNT_W'($urandom_range(9, MAX_FRAMES - 1));
        default: fc_raw = CNT_W'($urandom_range(2, 8));
      endcase
      sess++;
      wait_idle();
      write_cfg(CFG_FRAME_COUNT, fc_raw);
      write_cfg(CFG_INTERPOLATE, CFG_DATA_W'($urandom_range(0, 1)));
      fc_eff = int'(sb.frames_eff());
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      hot.delete();
      repeat ($urandom_range(1, 4)) hot.push_back(BIN_W'($urandom));

      if ($urandom_range(0, 3) != 0) begin
        send_req(CMD_ACQUIRE, BIN_W'($urandom), $urandom, $urandom,
                 1'($urandom_range(0, 1)), SETV_W'($urandom));
        n_rec = (fc_eff <= 8) ? fc_eff : $urandom_range(1, 3);
        // now and then break the capture off early
        if ($urandom_range(0, 7) == 0) n_rec = $urandom_range(0, n_rec);
        repeat (n_rec) begin
          foreach (hot[k]) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send_req(CMD_RECORD, hot[k], $urandom, $urandom, k == hot.size() - 1,
                     SETV_W'($urandom));
          end
        end
      end

      foreach (hot[k]) begin
        if ($urandom_range(0, 2) != 0)
          send_req(CMD_SET_INC, hot[k], $urandom, $urandom, 1'($urandom_range(0, 1)),
                   pick_setv(fc_eff));
        if ($urandom_range(0, 2) == 0)
          send_req(CMD_SET_PHASE, hot[k], $urandom, $urandom, 1'($urandom_range(0, 1)),
                   pick_setv(fc_eff));
      end

      repeat ($urandom_range(8, 24)) begin
        if ($urandom_range(0, 9) == 0)
          send_noise();
        else
          send_req(CMD_PLAY, hot[$urandom_range(0, hot.size() - 1)], $urandom, $urandom,
                   1'($urandom_range(0, 1)), SETV_W'($urandom));
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ spectral_frame_store_resampler_top.f @@
+incdir+rtl/core
rtl/core/sfsr_pkg.sv
rtl/core/sfsr_ram.sv
rtl/core/sfsr_wrap.sv
rtl/core/sfsr_lerp.sv
rtl/core/spectral_frame_store_resampler_top.sv
test/tb_spectral_frame_store_resampler_top.sv
